### rtl/b64d_pkg.sv
// Shared types, constants and the alphabet lookup of the base64 stream decoder.
package b64d_pkg;

    // Width of the saturating decoded-byte counter.
    localparam int COUNT_BITS = 24;
    // Width of the byte_count result field.
    localparam int BYTE_COUNT_W = 24;

    // Depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Input kind codes.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Result kind codes.
    localparam logic RES_DATA   = 1'b0;
    localparam logic RES_STATUS = 1'b1;

    // Status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // Special characters.
    localparam logic [7:0] CH_PAD = 8'h3D;  // '='
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    // Slot codes within a group of four characters.
    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;
    localparam logic [1:0] SLOT_2 = 2'd2;
    localparam logic [1:0] SLOT_3 = 2'd3;

    // One unit of work for the back end: a finished group or an end-of-string status.
    typedef struct packed {
        logic        is_status;
        logic        status;
        logic [1:0]  nbytes;   // 1..3 for a data group
        logic [23:0] word;     // byte 0 in [23:16]
    } t_job;

    // Alphabet lookup: {valid, sextet}.
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [6:0] res;
        res = 7'd0;
        if (ch inside {[8'h41:8'h5A]}) begin
            res = {1'b1, 6'(ch - 8'h41)};
        end else if (ch inside {[8'h61:8'h7A]}) begin
            res = {1'b1, 6'(ch - 8'h61 + 8'd26)};
        end else if (ch inside {[8'h30:8'h39]}) begin
            res = {1'b1, 6'(ch - 8'h30 + 8'd52)};
        end else if (ch == 8'h2B) begin
            res = {1'b1, 6'd62};
        end else if (ch == 8'h2F) begin
            res = {1'b1, 6'd63};
        end
        return res;
    endfunction

endpackage

### rtl/b64d_front.sv
// Front end: accepts characters, tracks the group state and issues jobs.
module b64d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic            i_kind,
    input  logic [7:0]      i_char_code,
    output logic            o_job_push,
    output b64d_pkg::t_job  o_job
);
    import b64d_pkg::*;

    logic [1:0]  r_pos,   n_pos;
    logic [1:0]  r_skips, n_skips;
    logic [17:0] r_acc,   n_acc;
    logic        r_pad,   n_pad;
    logic        r_stop,  n_stop;
    logic        r_err,   n_err;

    logic [6:0]  w_lut;
    logic        w_valid;
    logic [5:0]  w_sx;

    assign w_lut   = sextet_of(i_char_code);
    assign w_valid = w_lut[6];
    assign w_sx    = w_lut[5:0];

    always_comb begin
        n_pos      = r_pos;
        n_skips    = r_skips;
        n_acc      = r_acc;
        n_pad      = r_pad;
        n_stop     = r_stop;
        n_err      = r_err;
        o_job_push = 1'b0;
        o_job      = '0;
        if (i_take) begin
            if (i_kind == KIND_END) begin
                o_job_push      = 1'b1;
                o_job.is_status = 1'b1;
                o_job.status    = (r_err || (!r_stop && r_pos != SLOT_0)) ?
                                  STATUS_BAD : STATUS_OK;
                n_pos   = SLOT_0;
                n_skips = 2'd0;
                n_acc   = 18'd0;
                n_pad   = 1'b0;
                n_stop  = 1'b0;
                n_err   = 1'b0;
            end else if (!r_stop && !r_err) begin
                case (r_pos)
                    SLOT_0: begin
                        if ((i_char_code == CH_CR || i_char_code == CH_LF) &&
                            r_skips < 2'd2) begin
                            n_skips = r_skips + 2'd1;
                        end else if (!w_valid) begin
                            n_stop = 1'b1;
                        end else begin
                            n_acc   = {12'd0, w_sx};
                            n_skips = 2'd0;
                            n_pos   = SLOT_1;
                        end
                    end
                    SLOT_1: begin
                        if (!w_valid) begin
                            n_err = 1'b1;
                        end else begin
                            n_acc = {r_acc[11:0], w_sx};
                            n_pos = SLOT_2;
                        end
                    end
                    SLOT_2: begin
                        if (i_char_code == CH_PAD) begin
                            n_pad = 1'b1;
                            n_acc = {r_acc[11:0], 6'd0};
                            n_pos = SLOT_3;
                        end else if (!w_valid) begin
                            n_err = 1'b1;
                        end else begin
                            n_acc = {r_acc[11:0], w_sx};
                            n_pos = SLOT_3;
                        end
                    end
                    default: begin
                        if (i_char_code == CH_PAD) begin
                            n_stop       = 1'b1;
                            o_job_push   = 1'b1;
                            o_job.word   = {r_acc, 6'd0};
                            o_job.nbytes = r_pad ? 2'd1 : 2'd2;
                        end else if (r_pad || !w_valid) begin
                            n_err = 1'b1;
                        end else begin
                            o_job_push   = 1'b1;
                            o_job.word   = {r_acc, w_sx};
                            o_job.nbytes = 2'd3;
                            n_pos        = SLOT_0;
                            n_skips      = 2'd0;
                            n_acc        = 18'd0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= SLOT_0;
            r_skips <= 2'd0;
            r_acc   <= 18'd0;
            r_pad   <= 1'b0;
            r_stop  <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_skips <= n_skips;
            r_acc   <= n_acc;
            r_pad   <= n_pad;
            r_stop  <= n_stop;
            r_err   <= n_err;
        end
    end

endmodule

### rtl/b64d_queue.sv
// Short job queue between the front and back ends.
module b64d_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64d_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output b64d_pkg::t_job  o_head
);
    import b64d_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic                w_push, w_pop;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/b64d_back.sv
// Back end: expands jobs into result transactions and keeps the byte count.
module b64d_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_empty,
    input  b64d_pkg::t_job                       i_head,
    output logic                                 o_q_pop,
    input  logic                                 i_pop,
    output logic                                 o_empty,
    output logic                                 o_result_kind,
    output logic [7:0]                           o_data_byte,
    output logic                                 o_status_code,
    output logic [b64d_pkg::BYTE_COUNT_W-1:0]    o_byte_count,
    output logic                                 o_last_of_run
);
    import b64d_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                    r_out_valid;
    logic                    r_kind;
    logic [7:0]              r_byte;
    logic                    r_status;
    logic [BYTE_COUNT_W-1:0] r_count_out;
    logic                    r_last;
    logic [1:0]              r_idx, n_idx;
    logic [COUNT_BITS-1:0]   r_count, n_count, w_count_res;
    logic [BYTE_COUNT_W-1:0] w_count_ext;
    logic                    w_load, w_last;
    logic [7:0]              w_byte;

    assign w_load = (!r_out_valid || i_pop) && !i_q_empty;

    always_comb begin
        case (r_idx)
            2'd0:    w_byte = i_head.word[23:16];
            2'd1:    w_byte = i_head.word[15:8];
            default: w_byte = i_head.word[7:0];
        endcase
    end

    assign w_last  = i_head.is_status || (r_idx == i_head.nbytes - 2'd1);
    assign o_q_pop = w_load && w_last;

    always_comb begin
        n_idx       = r_idx;
        n_count     = r_count;
        w_count_res = r_count;
        if (w_load) begin
            n_idx = w_last ? 2'd0 : r_idx + 2'd1;
            if (i_head.is_status) begin
                n_count = '0;
            end else begin
                n_count     = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
                w_count_res = n_count;
            end
        end
    end

    generate
        if (COUNT_BITS >= BYTE_COUNT_W) begin : g_cnt_trunc
            assign w_count_ext = w_count_res[BYTE_COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign w_count_ext = {{(BYTE_COUNT_W-COUNT_BITS){1'b0}}, w_count_res};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind      <= i_head.is_status ? RES_STATUS : RES_DATA;
            r_byte      <= i_head.is_status ? 8'd0 : w_byte;
            r_status    <= i_head.is_status ? i_head.status : STATUS_OK;
            r_count_out <= w_count_ext;
            r_last      <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
            r_count     <= '0;
        end else begin
            r_idx   <= n_idx;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_result_kind = r_kind;
    assign o_data_byte   = r_byte;
    assign o_status_code = r_status;
    assign o_byte_count  = r_count_out;
    assign o_last_of_run = r_last;

endmodule

### rtl/base64_stream_decoder.sv
// Top level of the streaming base64 decoder: front end, job queue, back end.
//
//  channel   direction  handshake             payload
//  input     in         push / full           i_kind, i_char_code
//  result    out        empty / pop           o_result_kind, o_data_byte,
//                                             o_status_code, o_byte_count,
//                                             o_last_of_run
//
// One character transaction is taken per cycle while the job queue has room;
// the front end decides the character in the cycle it is taken.
// A finished group passes through the job queue into the result register
// and leaves as up to three transactions, one per cycle while pop stays high.
// full rises when the four-entry job queue fills, i.e. when pop stays low.
// Synchronous active-low reset clears group state, queue and byte count.
module base64_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [7:0]  i_char_code,
    output logic        empty,
    input  logic        pop,
    output logic        o_result_kind,
    output logic [7:0]  o_data_byte,
    output logic        o_status_code,
    output logic [23:0] o_byte_count,
    output logic        o_last_of_run
);
    import b64d_pkg::*;

    logic w_take;
    logic w_job_push;
    t_job w_job;
    logic w_q_full, w_q_empty, w_q_pop;
    t_job w_head;

    // An input transaction is taken whenever the queue can absorb a job.
    assign full   = w_q_full;
    assign w_take = push && !w_q_full;

    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_kind      (i_kind),
        .i_char_code (i_char_code),
        .o_job_push  (w_job_push),
        .o_job       (w_job)
    );

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_head)
    );

    // Back end drains one result per cycle into its output register while that register is empty or being popped.
    b64d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_head        (w_head),
        .o_q_pop       (w_q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_result_kind (o_result_kind),
        .o_data_byte   (o_data_byte),
        .o_status_code (o_status_code),
        .o_byte_count  (o_byte_count),
        .o_last_of_run (o_last_of_run)
    );

`ifndef SYNTHESIS
    // A status result always closes its transaction run.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind == RES_STATUS) |-> o_last_of_run)
        else $error("status result without last_of_run");

    // Status results carry a zero data byte.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind == RES_STATUS) |-> (o_data_byte == 8'd0))
        else $error("status result with nonzero data byte");

    // The front end never issues a job the queue cannot hold.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_push |-> !w_q_full)
        else $error("job pushed into full queue");

    // Data results stay valid and unchanged until popped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_byte_count) && $stable(o_data_byte)))
        else $error("result changed while waiting");
`endif

endmodule

### sim/base64_stream_decoder_tb.sv
// Self-checking testbench for the streaming base64 decoder: directed strings, random strings.
module base64_stream_decoder_tb;
    import b64d_pkg::*;

    // One result transaction as seen on the output ports.
    typedef struct packed {
        logic                    result_kind;
        logic [7:0]              data_byte;
        logic                    status_code;
        logic [BYTE_COUNT_W-1:0] byte_count;
        logic                    last_of_run;
    } t_b64_result;

    // Scoreboard: tracks the decode state of the current string and holds the
    // data bytes and status results still to come out of the block.
    class t_b64_scoreboard;
        int                    sextet_lut[256];   // char -> sextet, -1 if not in alphabet
        logic [1:0]            slot;              // next slot within the group
        logic [1:0]            nl_skips;          // CR/LF skipped at group start
        logic [17:0]           acc;               // sextets gathered so far
        bit                    pad3;              // '=' taken in slot three
        bit                    done_clean;        // decode ended without error
        bit                    malformed;         // error seen, rest ignored
        logic [COUNT_BITS-1:0] bytes_out;         // saturating byte count
        t_b64_result           decoded_q[$];
        int                    mismatches;

        function new(string alphabet);
            foreach (sextet_lut[i]) sextet_lut[i] = -1;
            for (int i = 0; i < alphabet.len(); i++) sextet_lut[alphabet[i]] = i;
            mismatches = 0;
            clear_string();
        endfunction

        function void clear_string();
            slot       = SLOT_0;
            nl_skips   = 2'd0;
            acc        = 18'd0;
            pad3       = 1'b0;
            done_clean = 1'b0;
            malformed  = 1'b0;
            bytes_out  = '0;
        endfunction

        // Queue n bytes from the top of a 24-bit group word.
        function void push_bytes(logic [23:0] word, int n);
            t_b64_result r;
            for (int k = 0; k < n; k++) begin
                if (bytes_out != {COUNT_BITS{1'b1}}) bytes_out++;
                r.result_kind = RES_DATA;
                r.data_byte   = word[23 - 8 * k -: 8];
                r.status_code = STATUS_OK;
                r.byte_count  = BYTE_COUNT_W'(bytes_out);
                r.last_of_run = (k == n - 1);
                decoded_q.push_back(r);
            end
        endfunction

        // Accepted input transaction: advance the decode and note what it yields.
        function void take_input(logic kind, logic [7:0] ch);
            int          v;
            logic [23:0] word;
            t_b64_result r;
            if (kind == KIND_END) begin
                r.result_kind = RES_STATUS;
                r.data_byte   = 8'd0;
                r.status_code = (malformed || (!done_clean && slot != SLOT_0)) ?
                                STATUS_BAD : STATUS_OK;
                r.byte_count  = BYTE_COUNT_W'(bytes_out);
                r.last_of_run = 1'b1;
                decoded_q.push_back(r);
                clear_string();
                return;
            end
            if (done_clean || malformed) return;
            v = sextet_lut[ch];
            case (slot)
                SLOT_0: begin
                    if ((ch == CH_CR || ch == CH_LF) && nl_skips < 2) begin
                        nl_skips++;
                    end else if (v < 0) begin
                        done_clean = 1'b1;
                    end else begin
                        acc      = 18'(v);
                        nl_skips = 2'd0;
                        slot     = SLOT_1;
                    end
                end
                SLOT_1: begin
                    if (v < 0) begin
                        malformed = 1'b1;
                    end else begin
                        acc  = {acc[11:0], 6'(v)};
                        slot = SLOT_2;
                    end
                end
                SLOT_2: begin
                    if (ch == CH_PAD) begin
                        pad3 = 1'b1;
                        acc  = {acc[11:0], 6'd0};
                        slot = SLOT_3;
                    end else if (v < 0) begin
                        malformed = 1'b1;
                    end else begin
                        acc  = {acc[11:0], 6'(v)};
                        slot = SLOT_3;
                    end
                end
                default: begin
                    word = {acc, 6'd0};
                    if (ch == CH_PAD) begin
                        done_clean = 1'b1;
                        push_bytes(word, pad3 ? 1 : 2);
                    end else if (pad3 || v < 0) begin
                        malformed = 1'b1;
                    end else begin
                        word[5:0] = 6'(v);
                        slot      = SLOT_0;
                        nl_skips  = 2'd0;
                        acc       = 18'd0;
                        push_bytes(word, 3);
                    end
                end
            endcase
        endfunction

        function void report(string what, t_b64_result want, t_b64_result got);
            mismatches++;
            if (mismatches <= 10)
                $display({"%s: expected kind=%0d byte=%02h status=%0d count=%0d last=%0d,",
                          " got kind=%0d byte=%02h status=%0d count=%0d last=%0d"},
                         what, want.result_kind, want.data_byte, want.status_code,
                         want.byte_count, want.last_of_run, got.result_kind, got.data_byte,
                         got.status_code, got.byte_count, got.last_of_run);
        endfunction

        // Accepted result transaction: compare with the oldest pending one.
        function void check_output(t_b64_result got);
            t_b64_result want;
            if (decoded_q.size() == 0) begin
                report("result with nothing pending", '0, got);
                return;
            end
            want = decoded_q.pop_front();
            if (got.result_kind !== want.result_kind || got.data_byte !== want.data_byte ||
                got.status_code !== want.status_code || got.byte_count !== want.byte_count ||
                got.last_of_run !== want.last_of_run)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_kind;
    logic [7:0]  i_char_code;
    logic        empty;
    logic        pop;
    logic        o_result_kind;
    logic [7:0]  o_data_byte;
    logic        o_status_code;
    logic [23:0] o_byte_count;
    logic        o_last_of_run;

    string                b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    t_b64_scoreboard      sb;
    bit                   quiet_tail;   // no idling on either side near the end
    int                   items_sent;
    int                   char_pos;     // alphabet-slot counter within a random string
    int                   corrupt_at;   // slot that gets a random byte, -1 for none

    base64_stream_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_kind        (i_kind),
        .i_char_code   (i_char_code),
        .empty         (empty),
        .pop           (pop),
        .o_result_kind (o_result_kind),
        .o_data_byte   (o_data_byte),
        .o_status_code (o_status_code),
        .o_byte_count  (o_byte_count),
        .o_last_of_run (o_last_of_run)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Sender: optional idle burst, then hold push until the block takes the
    // transaction. full is sampled at the edge, so it is the pre-edge value.
    task automatic send_item(input logic kind, input logic [7:0] ch);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_kind      <= kind;
        i_char_code <= ch;
        do @(posedge i_clk); while (full);
        sb.take_input(kind, ch);
        items_sent++;
    endtask

    task automatic send_end();
        send_item(KIND_END, 8'($urandom));   // char byte is don't-care here
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(KIND_CHAR, s[i]);
    endtask

    // Alphabet character, or a random byte at the chosen corruption slot.
    task automatic send_data_char(input logic [7:0] ch);
        logic [7:0] c;
        c = (char_pos == corrupt_at) ? 8'($urandom) : ch;
        char_pos++;
        send_item(KIND_CHAR, c);
    endtask

    function automatic logic [7:0] pick_b64_char();
        return b64_alphabet[$urandom_range(0, 63)];
    endfunction

    // Stop sending until every pending result has come out.
    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (sb.decoded_q.size() != 0);
    endtask

    // One random string: mostly well-formed groups with random content and
    // optional line breaks, some corrupted or cut short, some pure noise.
    task automatic send_random_string();
        int mode;
        int groups;
        int tail;
        mode = $urandom_range(0, 9);
        if (mode == 9) begin
            repeat ($urandom_range(1, 6)) send_item(KIND_CHAR, 8'($urandom));
            send_end();
            return;
        end
        groups     = $urandom_range(0, 4);
        char_pos   = 0;
        corrupt_at = (mode >= 7) ? $urandom_range(0, groups * 4 + 3) : -1;
        for (int g = 0; g < groups; g++) begin
            repeat ($urandom_range(0, 2))
                send_item(KIND_CHAR, $urandom_range(0, 1) ? CH_CR : CH_LF);
            repeat (4) send_data_char(pick_b64_char());
        end
        tail = $urandom_range(0, (mode >= 7) ? 3 : 2);
        case (tail)
            1: begin  // one-byte group: two chars and two pads
                repeat (2) send_data_char(pick_b64_char());
                repeat (2) send_data_char(CH_PAD);
            end
            2: begin  // two-byte group: three chars and one pad
                repeat (3) send_data_char(pick_b64_char());
                send_data_char(CH_PAD);
            end
            3: begin  // string ends inside a group
                repeat ($urandom_range(1, 3)) send_data_char(pick_b64_char());
            end
            default: ;
        endcase
        // trailing characters: ignored after a stop, decoded after a cut-short group
        if (tail != 0 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_item(KIND_CHAR, pick_b64_char());
        send_end();
    endtask

    // Receiver: check at each edge where a result transaction completes, then
    // pick pop for the next cycle with random stall bursts.
    initial begin
        t_b64_result got;
        int          stall;
        stall = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                got.result_kind = o_result_kind;
                got.data_byte   = o_data_byte;
                got.status_code = o_status_code;
                got.byte_count  = o_byte_count;
                got.last_of_run = o_last_of_run;
                sb.check_output(got);
            end
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                pop <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 9) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Main sequence.
    initial begin
        bit mid_drained;
        mid_drained = 1'b0;
        sb          = new(b64_alphabet);
        quiet_tail  = 1'b0;
        items_sent  = 0;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_kind      <= KIND_CHAR;
        i_char_code <= 8'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // line breaks skipped, full group, then '=' in slots three and four
        send_text("\r\nTWFuTW==");
        send_end();
        // extreme alphabet chars, '=' in slot four only
        send_text("//+=");
        send_end();
        // third line break counts as an invalid first char: clean stop
        send_text("\n\r\n");
        send_end();
        // pad as second char is an error
        send_text("A=");
        send_end();
        // zero byte after a slot-three pad is an error
        send_text("AB=");
        send_item(KIND_CHAR, 8'h00);
        send_end();
        // end of string inside a group
        send_text("ABC");
        send_end();
        wait_drained();

        while (items_sent < 170) begin
            if (items_sent >= 145) quiet_tail = 1'b1;
            if (!mid_drained && items_sent >= 90) begin
                wait_drained();
                mid_drained = 1'b1;
            end
            send_random_string();
        end
        push <= 1'b0;

        while (sb.decoded_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.decoded_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder.sv
sim/base64_stream_decoder_tb.sv
